### rtl/core/skf_pkg.sv
`timescale 1ns / 1ps
package skf_pkg;

	localparam int PACKET_DEPTH = 2048;
	localparam int CNT_W        = $clog2(PACKET_DEPTH + 1);
	localparam int POS_W        = $clog2(PACKET_DEPTH);

	localparam int NUM_KW = 10;
	localparam int WIN    = 11;
	localparam int IDX_W  = $clog2(WIN);

	localparam int CODE_W    = 4;
	localparam int START_W   = 11;
	localparam int SPANLEN_W = 12;

	localparam int LONG_LIM  = 10;
	localparam int SHORT_LIM = 7;
	localparam int MIN_LEN   = 10;

	typedef logic [7:0] byte_t;

	localparam byte_t DELIM = 8'h07;

	localparam byte_t KW_CHARS [NUM_KW][WIN] = '{
		'{"A", "L", "T", "E", "R", " ", "T", "A", "B", "L", "E"},
		'{"a", "l", "t", "e", "r", " ", "t", "a", "b", "l", "e"},
		'{"I", "N", "S", "E", "R", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"i", "n", "s", "e", "r", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"U", "P", "D", "A", "T", "E", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"u", "p", "d", "a", "t", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"d", "e", "l", "e", "t", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"s", "e", "l", "e", "c", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"S", "E", "L", "E", "C", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [IDX_W-1:0] KW_LEN [NUM_KW] = '{
		IDX_W'(11), IDX_W'(11), IDX_W'(6), IDX_W'(6), IDX_W'(6),
		IDX_W'(6), IDX_W'(6), IDX_W'(6), IDX_W'(6), IDX_W'(6)
	};

	localparam logic [NUM_KW-1:0] KW_LONG = NUM_KW'(10'b00_0000_0011);

	typedef struct packed {
		logic [CNT_W-1:0]             len;
		logic [NUM_KW-1:0]            seen;
		logic [NUM_KW-1:0][POS_W-1:0] first;
		logic                         short_ok;
		logic [POS_W-1:0]             short_d;
		logic                         long_ok;
		logic [POS_W-1:0]             long_d;
	} snap_t;

endpackage

### rtl/core/skf_in_if.sv
`timescale 1ns / 1ps
interface skf_in_if;
	import skf_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/core/skf_out_if.sv
`timescale 1ns / 1ps
interface skf_out_if;
	import skf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [CODE_W-1:0]    keyword_code;
	logic [START_W-1:0]   span_start;
	logic [SPANLEN_W-1:0] span_length;

	modport source (output valid, output found, output keyword_code, output span_start,
		output span_length, input ready);
	modport sink (input valid, input found, input keyword_code, input span_start,
		input span_length, output ready);
endinterface

### rtl/core/skf_cell.sv
`timescale 1ns / 1ps
module skf_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         clr,
	input  logic [skf_pkg::IDX_W-1:0]    idx,
	input  skf_pkg::byte_t               d,
	output skf_pkg::byte_t               q,
	output logic [skf_pkg::NUM_KW-1:0]   match
);
	import skf_pkg::*;

	byte_t held_q;

	// compare the incoming byte with the keyword char due at this window slot
	always_comb begin
		logic [IDX_W-1:0] sel;
		for (int k = 0; k < NUM_KW; k++) begin
			sel = KW_LEN[k] - IDX_W'(1) - idx;
			if (idx < KW_LEN[k]) begin
				match[k] = (d == KW_CHARS[k][sel]);
			end else begin
				match[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (clr) begin
			held_q <= '0;
		end else if (en) begin
			held_q <= d;
		end
	end

	assign q = held_q;
endmodule

### rtl/core/skf_report.sv
`timescale 1ns / 1ps
module skf_report (
	input  logic            clk,
	input  logic            arst_n,
	input  skf_pkg::snap_t  snap,
	input  logic            snap_valid,
	output logic            snap_ready,
	skf_out_if.source       res
);
	import skf_pkg::*;

	logic                 sel;
	logic [CODE_W-1:0]    sel_k;
	logic [POS_W-1:0]     sel_start;
	logic                 sel_long;
	logic                 d_ok;
	logic [POS_W-1:0]     d;
	logic [CNT_W-1:0]     span_end;
	logic [CNT_W-1:0]     span_len;
	logic                 load;

	logic                 valid_q;
	logic                 found_q;
	logic [CODE_W-1:0]    code_q;
	logic [START_W-1:0]   start_q;
	logic [SPANLEN_W-1:0] len_q;

	// priority pick: lowest code wins
	always_comb begin
		logic [CNT_W:0] lim_sum;
		sel       = 1'b0;
		sel_k     = '0;
		sel_start = '0;
		sel_long  = 1'b0;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			lim_sum = (CNT_W + 1)'(snap.first[k])
				+ (CNT_W + 1)'(KW_LONG[k] ? LONG_LIM : SHORT_LIM);
			if (snap.seen[k] && (snap.first[k] != '0)
					&& (lim_sum < {1'b0, snap.len})) begin
				sel       = 1'b1;
				sel_k     = CODE_W'(k);
				sel_start = snap.first[k];
				sel_long  = KW_LONG[k];
			end
		end
		if (snap.len <= CNT_W'(MIN_LEN)) begin
			sel = 1'b0;
		end
	end

	assign d_ok     = sel_long ? snap.long_ok : snap.short_ok;
	assign d        = sel_long ? snap.long_d : snap.short_d;
	assign span_end = (d_ok && (d > sel_start)) ? CNT_W'(d) : snap.len;
	assign span_len = span_end - CNT_W'(sel_start);

	assign snap_ready = !valid_q || res.ready;
	assign load       = snap_valid && snap_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			found_q <= sel;
			code_q  <= sel ? sel_k : '0;
			start_q <= sel ? START_W'(sel_start) : '0;
			len_q   <= sel ? SPANLEN_W'(span_len) : '0;
		end
	end

	assign res.valid        = valid_q;
	assign res.found        = found_q;
	assign res.keyword_code = code_q;
	assign res.span_start   = start_q;
	assign res.span_length  = len_q;

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.found |-> res.keyword_code < CODE_W'(NUM_KW))
		else $error("keyword code out of range");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.found |-> (res.keyword_code == '0) && (res.span_start == '0)
			&& (res.span_length == '0))
		else $error("miss word carries nonzero fields");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> res.valid)
		else $error("loaded word not presented");
endmodule

### rtl/core/sql_keyword_span_finder_core.sv
`timescale 1ns / 1ps
// channel | dir | payload                                           | handshake
// pkt     | in  | data_byte[7:0], last_byte                          | valid/ready
// res     | out | found, keyword_code[3:0], span_start[10:0],        | valid/ready
//         |     | span_length[11:0]                                  |
//
// One byte per cycle while pkt.ready is high, set by the 11-cell byte window and its per-cell compares.
// A result leaves after its last byte through the snapshot stage, then the output register.
// arst_n clears window, counters and hit flags; no clearing pass.
// Per-packet state clears on the accepted last byte; the next packet may follow at once.
// pkt.ready drops only while the snapshot is held behind a stalled output word.
module sql_keyword_span_finder_core (
	input  logic      clk,
	input  logic      arst_n,
	skf_in_if.sink    pkt,
	skf_out_if.source res
);
	import skf_pkg::*;

	logic                         acc;
	logic                         take;
	logic                         fin;
	byte_t                        chain [WIN];
	byte_t                        win [WIN];
	byte_t                        win_nx [WIN];
	logic [WIN-1:0][NUM_KW-1:0]   cell_match;
	logic [NUM_KW-1:0]            hit;
	logic [POS_W-1:0]             pos;

	logic [CNT_W-1:0]             cnt_q;
	logic [NUM_KW-1:0]            seen_q;
	logic [NUM_KW-1:0][POS_W-1:0] first_q;
	logic [POS_W-1:0]             older_pos_q;
	logic                         older_seen_q;

	logic [CNT_W-1:0]             cnt_nx;
	logic [NUM_KW-1:0]            seen_nx;
	logic [NUM_KW-1:0][POS_W-1:0] first_nx;
	logic [POS_W-1:0]             older_pos_nx;
	logic                         older_seen_nx;

	snap_t                        snap_nx;
	snap_t                        snap_s1;
	logic                         snap_valid_s1;
	logic                         snap_ready;

	assign acc  = pkt.valid && pkt.ready;
	assign take = acc && (cnt_q < CNT_W'(PACKET_DEPTH));
	assign fin  = acc && pkt.last_byte;
	assign pos  = POS_W'(cnt_q);

	assign pkt.ready = !snap_valid_s1 || snap_ready;

	for (genvar i = 0; i < WIN; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign chain[i] = pkt.data_byte;
		end else begin : g_link
			assign chain[i] = win[i-1];
		end

		skf_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (take),
			.clr   (fin),
			.idx   (IDX_W'(i)),
			.d     (chain[i]),
			.q     (win[i]),
			.match (cell_match[i])
		);

		assign win_nx[i] = take ? chain[i] : win[i];
	end

	always_comb begin
		for (int k = 0; k < NUM_KW; k++) begin
			hit[k] = 1'b1;
			for (int i = 0; i < WIN; i++) begin
				hit[k] = hit[k] & cell_match[i][k];
			end
		end
	end

	always_comb begin
		cnt_nx        = take ? cnt_q + CNT_W'(1) : cnt_q;
		older_pos_nx  = older_pos_q;
		older_seen_nx = older_seen_q;
		if (take && (win[WIN-1] == DELIM)) begin
			older_pos_nx  = pos - POS_W'(WIN);
			older_seen_nx = 1'b1;
		end
		for (int k = 0; k < NUM_KW; k++) begin
			seen_nx[k]  = seen_q[k] | (take & hit[k]);
			first_nx[k] = first_q[k];
			if (take && hit[k] && !seen_q[k]) begin
				first_nx[k] = pos - POS_W'(KW_LEN[k]) + POS_W'(1);
			end
		end
	end

	// snapshot of length and keyword hits, with delimiter candidates as seen from the packet end
	always_comb begin
		snap_nx.len      = cnt_nx;
		snap_nx.seen     = seen_nx;
		snap_nx.first    = first_nx;
		snap_nx.short_ok = older_seen_nx;
		snap_nx.short_d  = older_pos_nx;
		for (int k = WIN - 1; k >= SHORT_LIM; k--) begin
			if (win_nx[k] == DELIM) begin
				snap_nx.short_ok = 1'b1;
				snap_nx.short_d  = POS_W'(cnt_nx - CNT_W'(k + 1));
			end
		end
		if (win_nx[WIN-1] == DELIM) begin
			snap_nx.long_ok = 1'b1;
			snap_nx.long_d  = POS_W'(cnt_nx - CNT_W'(WIN));
		end else begin
			snap_nx.long_ok = older_seen_nx;
			snap_nx.long_d  = older_pos_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			seen_q       <= '0;
			first_q      <= '0;
			older_pos_q  <= '0;
			older_seen_q <= 1'b0;
		end else if (fin) begin
			cnt_q        <= '0;
			seen_q       <= '0;
			first_q      <= '0;
			older_pos_q  <= '0;
			older_seen_q <= 1'b0;
		end else if (take) begin
			cnt_q        <= cnt_nx;
			seen_q       <= seen_nx;
			first_q      <= first_nx;
			older_pos_q  <= older_pos_nx;
			older_seen_q <= older_seen_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (fin) begin
			snap_valid_s1 <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			snap_s1 <= snap_nx;
		end
	end

	skf_report u_report (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap      (snap_s1),
		.snap_valid(snap_valid_s1),
		.snap_ready(snap_ready),
		.res       (res)
	);

	a_fin_snap: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> snap_valid_s1)
		else $error("last byte left no snapshot");

	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PACKET_DEPTH))
		else $error("byte count past depth");

	a_fin_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> (cnt_q == '0) && (seen_q == '0) && !older_seen_q)
		else $error("packet state not cleared");
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import skf_pkg::*;

	localparam int IDLE_LIMIT   = 3000;
	localparam int RANDOM_BYTES = 1200;
	localparam int LONG_HOLD    = 300;

	typedef enum logic [CODE_W-1:0] {
		KW_ALTER_TABLE_UC = 4'd0,
		KW_ALTER_TABLE_LC = 4'd1,
		KW_INSERT_UC      = 4'd2,
		KW_INSERT_LC      = 4'd3,
		KW_UPDATE_UC      = 4'd4,
		KW_UPDATE_LC      = 4'd5,
		KW_DELETE_UC      = 4'd6,
		KW_DELETE_LC      = 4'd7,
		KW_SELECT_LC      = 4'd8,
		KW_SELECT_UC      = 4'd9
	} kw_code_e;

	typedef struct {
		bit                   found;
		kw_code_e             code;
		logic [START_W-1:0]   start;
		logic [SPANLEN_W-1:0] length;
	} span_report_t;

	class keyword_span_tracker;
		string            kw_text [NUM_KW];
		logic [CNT_W-1:0] stored;
		byte_t            window [WIN];
		logic [POS_W-1:0] first_pos [NUM_KW];
		bit               hit [NUM_KW];
		logic [POS_W-1:0] old_delim_pos;
		bit               old_delim_seen;
		span_report_t     pending [$];
		int               errors;

		function new();
			kw_text = '{"ALTER TABLE", "alter table", "INSERT", "insert", "UPDATE",
				"update", "DELETE", "delete", "select", "SELECT"};
			errors = 0;
			clear();
		endfunction

		function void clear();
			stored = '0;
			old_delim_pos = '0;
			old_delim_seen = 0;
			foreach (window[i]) window[i] = '0;
			foreach (hit[i]) begin
				hit[i] = 0;
				first_pos[i] = '0;
			end
		endfunction

		function void note_byte(byte_t b, bit last);
			int pos, n, k, j, len, lim, start, stop, d;
			bit hit_now, got;
			span_report_t rep;
			if (stored < PACKET_DEPTH) begin
				pos = stored;
				// delimiter about to fall out of the window
				if (pos >= WIN && window[WIN-1] == DELIM) begin
					old_delim_pos = POS_W'(pos - WIN);
					old_delim_seen = 1;
				end
				for (k = WIN - 1; k > 0; k--) window[k] = window[k-1];
				window[0] = b;
				for (k = 0; k < NUM_KW; k++) begin
					n = kw_text[k].len();
					hit_now = (pos + 1 >= n);
					for (j = 0; hit_now && j < n; j++)
						if (window[n-1-j] != byte_t'(kw_text[k][j])) hit_now = 0;
					if (hit_now && !hit[k]) begin
						hit[k] = 1;
						first_pos[k] = POS_W'(pos + 1 - n);
					end
				end
				stored = CNT_W'(pos + 1);
			end
			if (!last) return;
			rep.found = 0;
			rep.code = KW_ALTER_TABLE_UC;
			rep.start = '0;
			rep.length = '0;
			len = stored;
			if (len > MIN_LEN) begin
				for (k = 0; k < NUM_KW && !rep.found; k++) begin
					n = kw_text[k].len();
					lim = len - (n == WIN ? LONG_LIM : SHORT_LIM);
					start = first_pos[k];
					if (hit[k] && start != 0 && start < lim) begin
						stop = len;
						got = 0;
						d = 0;
						for (j = 0; j < WIN && j < len && !got; j++)
							if (len - 1 - j < lim && window[j] == DELIM) begin
								d = len - 1 - j;
								got = 1;
							end
						if (!got && old_delim_seen && old_delim_pos < lim) begin
							d = old_delim_pos;
							got = 1;
						end
						if (got && d > start) stop = d;
						rep.found = 1;
						rep.code = kw_code_e'(k);
						rep.start = START_W'(start);
						rep.length = SPANLEN_W'(stop - start);
					end
				end
			end
			pending.push_back(rep);
			clear();
		endfunction

		function void check_report(logic f, logic [CODE_W-1:0] c, logic [START_W-1:0] s,
			logic [SPANLEN_W-1:0] l);
			span_report_t want;
			if (pending.size() == 0) begin
				$error("result word with no report expected");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (f !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, f);
				errors++;
			end
			if (c !== want.code) begin
				$error("keyword_code: expected %0d, got %0d", want.code, c);
				errors++;
			end
			if (s !== want.start) begin
				$error("span_start: expected %0d, got %0d", want.start, s);
				errors++;
			end
			if (l !== want.length) begin
				$error("span_length: expected %0d, got %0d", want.length, l);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	skf_in_if  pkt_ch ();
	skf_out_if res_ch ();

	sql_keyword_span_finder_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.res    (res_ch)
	);

	keyword_span_tracker sb;
	byte_t pkt_bytes [$];
	int    bytes_sent;
	int    reports_seen;
	int    sink_hold;
	bit    sink_burst;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic load_text(string s);
		pkt_bytes.delete();
		for (int i = 0; i < s.len(); i++) pkt_bytes.push_back(byte_t'(s[i]));
	endtask

	task automatic make_random_packet(int plen);
		string pool;
		int eff, nkw, code, n, at, r, nd;
		bit raw;
		pool = "ALTERBINSUPDCOaltebinsupdco ";
		eff = (plen > PACKET_DEPTH) ? PACKET_DEPTH : plen;
		raw = ($urandom_range(0, 1) == 0);
		pkt_bytes.delete();
		for (int i = 0; i < plen; i++) begin
			if (raw || $urandom_range(0, 7) == 0)
				pkt_bytes.push_back(byte_t'($urandom_range(0, 255)));
			else
				pkt_bytes.push_back(byte_t'(pool[$urandom_range(0, pool.len() - 1)]));
		end
		nkw = $urandom_range(0, 3);
		for (int q = 0; q < nkw; q++) begin
			code = $urandom_range(0, NUM_KW - 1);
			n = sb.kw_text[code].len();
			if (n <= eff) begin
				r = $urandom_range(0, 9);
				if (r < 2)
					at = 0;
				else if (r < 5)
					at = eff - n - $urandom_range(0, 2);
				else
					at = $urandom_range(0, eff - n);
				if (at < 0) at = 0;
				for (int j = 0; j < n; j++) pkt_bytes[at+j] = byte_t'(sb.kw_text[code][j]);
				// broken keyword: flip bit 5 (the case bit of a letter) of one byte
				if ($urandom_range(0, 6) == 0) begin
					r = at + $urandom_range(0, n - 1);
					pkt_bytes[r] = pkt_bytes[r] ^ 8'h20;
				end
			end
		end
		nd = $urandom_range(0, 3);
		for (int q = 0; q < nd; q++) begin
			if ($urandom_range(0, 1) == 0)
				at = $urandom_range(0, plen - 1);
			else
				at = eff - $urandom_range(6, 12);
			if (at < 0) at = 0;
			pkt_bytes[at] = DELIM;
		end
	endtask

	task automatic send_packet();
		bit steady;
		int r;
		steady = ($urandom_range(0, 9) < 3);
		for (int i = 0; i < pkt_bytes.size(); i++) begin
			pkt_ch.valid     <= 1'b1;
			pkt_ch.data_byte <= pkt_bytes[i];
			pkt_ch.last_byte <= (i == pkt_bytes.size() - 1);
			do @(posedge clk); while (!pkt_ch.ready);
			sb.note_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
			bytes_sent++;
			if (!steady) begin
				r = $urandom_range(0, 99);
				if (r >= 70) begin
					pkt_ch.valid <= 1'b0;
					if (r < 95)
						repeat ($urandom_range(1, 3)) @(posedge clk);
					else
						repeat ($urandom_range(10, 40)) @(posedge clk);
				end
			end
		end
	endtask

	task automatic wait_drained();
		pkt_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// result side
	initial begin
		res_ch.ready = 1'b0;
		reports_seen = 0;
		sink_hold = 0;
		sink_burst = 0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				sb.check_report(res_ch.found, res_ch.keyword_code, res_ch.span_start,
					res_ch.span_length);
				reports_seen++;
				if (reports_seen == 25) sink_hold = LONG_HOLD;
			end
			if ($urandom_range(0, 49) == 0) sink_burst = ~sink_burst;
			if (sink_hold > 0) begin
				res_ch.ready <= 1'b0;
				sink_hold--;
			end else if (sink_burst) begin
				res_ch.ready <= 1'b1;
			end else begin
				case ($urandom_range(0, 19))
					0: begin
						res_ch.ready <= 1'b0;
						sink_hold = $urandom_range(5, 30);
					end
					1, 2, 3, 4, 5: res_ch.ready <= 1'b0;
					default: res_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// stall watchdog
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int plen, r;
		bit paused;
		sb = new();
		bytes_sent = 0;
		paused = 0;
		arst_n = 1'b0;
		pkt_ch.valid = 1'b0;
		pkt_ch.data_byte = '0;
		pkt_ch.last_byte = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte packet
		load_text("x");
		pkt_bytes[0] = 8'h00;
		send_packet();
		// ten bytes: too short even with a keyword
		load_text(" SELECTabc");
		send_packet();
		// shortest packet that reports
		load_text("~SELECT?xab");
		pkt_bytes[0] = 8'hff;
		pkt_bytes[7] = DELIM;
		send_packet();
		load_text("?ALTER TABLE");
		send_packet();
		wait_drained();

		while (bytes_sent < RANDOM_BYTES) begin
			if (!paused && bytes_sent > RANDOM_BYTES / 2) begin
				wait_drained();
				paused = 1;
			end
			r = $urandom_range(0, 99);
			if (r < 10)
				plen = $urandom_range(1, 10);
			else if (r < 85)
				plen = $urandom_range(11, 48);
			else
				plen = $urandom_range(49, 160);
			make_random_packet(plen);
			send_packet();
		end
		// overlong packet, tail bytes dropped
		make_random_packet($urandom_range(PACKET_DEPTH + 1, PACKET_DEPTH + 12));
		send_packet();

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d reports never arrived", sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/core/skf_pkg.sv
rtl/core/skf_in_if.sv
rtl/core/skf_out_if.sv
rtl/core/skf_cell.sv
rtl/core/skf_report.sv
rtl/core/sql_keyword_span_finder_core.sv
tb/tb.sv
